[src/rrts_pkg.sv]
// Shared types and constants of the round-robin thread scheduler.
package rrts_pkg;

    localparam int CNT_W = 31;
    localparam logic [CNT_W-1:0] CNT_MAX = 31'h7FFF_FFFF;

    // Event codes
    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_SPAWN  = 3'd1,
        OP_TERM   = 3'd2,
        OP_BLOCK  = 3'd3,
        OP_RESUME = 3'd4,
        OP_SLEEP  = 3'd5,
        OP_QUERY  = 3'd6
    } t_op;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_FULL      = 3'd2,
        ST_NULL      = 3'd3,
        ST_BAD_SLEEP = 3'd4,
        ST_EXIT      = 3'd5
    } t_status;

    // Thread modes
    typedef enum logic [1:0] {
        MODE_READY = 2'd0,
        MODE_RUN   = 2'd1,
        MODE_BLOCK = 2'd2,
        MODE_SLEEP = 2'd3
    } t_mode;

    // Datapath actions issued by the controller
    typedef enum logic [4:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_RESET_ALL,
        ACT_SPAWN_START,
        ACT_SPAWN_STEP,
        ACT_SPAWN_TAKE,
        ACT_TERM,
        ACT_MODE,
        ACT_RESUME_PUSH,
        ACT_SLEEP,
        ACT_NQ_START,
        ACT_WAKE_STEP,
        ACT_REQUEUE,
        ACT_POP,
        ACT_RUN_WR,
        ACT_RM_START,
        ACT_RM_STEP,
        ACT_RM_END,
        ACT_RES_OUT
    } t_act;

    typedef struct packed {
        t_act    act;
        logic    set_status;
        t_status status;
        t_mode   mode;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       tid_valid;
        logic       tid_zero;
        t_mode      tid_mode;
        logic       tid_pend;
        logic       entry_zero;
        logic       full;
        logic       cur_zero;
        logic       nq_zero;
        logic       spawn_end;
        logic       spawn_free;
        logic       wake_done;
        logic       q_empty;
        logic       rm_done;
        logic       out_free;
    } t_dp_stat;

endpackage

[src/rrts_ram.sv]
// Generic simple dual-port RAM with registered read.
module rrts_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/rrts_ctrl.sv]
// Controller state machine of the thread scheduler.
module rrts_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  rrts_pkg::t_dp_stat i_stat,
    output rrts_pkg::t_dp_cmd  o_cmd
);

    import rrts_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_DECODE  = 12'b0000_0000_0010,
        S_SPAWN   = 12'b0000_0000_0100,
        S_NQ      = 12'b0000_0000_1000,
        S_WAKE    = 12'b0000_0001_0000,
        S_POP_RD  = 12'b0000_0010_0000,
        S_POP     = 12'b0000_0100_0000,
        S_RUN_INC = 12'b0000_1000_0000,
        S_RM_INIT = 12'b0001_0000_0000,
        S_RM      = 12'b0010_0000_0000,
        S_RES_RD  = 12'b0100_0000_0000,
        S_RES     = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    // Next state and datapath commands
    always_comb begin
        n_state          = r_state;
        o_cmd.act        = ACT_NONE;
        o_cmd.set_status = 1'b0;
        o_cmd.status     = ST_OK;
        o_cmd.mode       = MODE_READY;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.act = ACT_LOAD;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_RES_RD;
                case (i_stat.op)
                    OP_TICK: begin
                        n_state = S_NQ;
                    end
                    OP_SPAWN: begin
                        if (i_stat.entry_zero) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_NULL;
                        end else if (i_stat.full) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_FULL;
                        end else begin
                            o_cmd.act = ACT_SPAWN_START;
                            n_state   = S_SPAWN;
                        end
                    end
                    OP_TERM: begin
                        if (!i_stat.tid_valid) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_INVALID;
                        end else if (i_stat.tid_zero) begin
                            // main thread exit: back to reset state
                            o_cmd.act        = ACT_RESET_ALL;
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_EXIT;
                        end else begin
                            o_cmd.act = ACT_TERM;
                            if (i_stat.tid_mode == MODE_RUN) begin
                                n_state = S_NQ;
                            end else if (i_stat.tid_mode == MODE_READY) begin
                                n_state = S_RM_INIT;
                            end
                        end
                    end
                    OP_BLOCK: begin
                        if (!i_stat.tid_valid || i_stat.tid_zero) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_INVALID;
                        end else begin
                            o_cmd.act  = ACT_MODE;
                            o_cmd.mode = MODE_BLOCK;
                            if (i_stat.tid_mode == MODE_RUN) begin
                                n_state = S_NQ;
                            end else if (i_stat.tid_mode == MODE_READY) begin
                                n_state = S_RM_INIT;
                            end
                        end
                    end
                    OP_RESUME: begin
                        if (!i_stat.tid_valid) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_INVALID;
                        end else if (i_stat.tid_mode == MODE_BLOCK) begin
                            if (i_stat.tid_pend) begin
                                o_cmd.act  = ACT_MODE;
                                o_cmd.mode = MODE_SLEEP;
                            end else begin
                                o_cmd.act = ACT_RESUME_PUSH;
                            end
                        end
                    end
                    OP_SLEEP: begin
                        if (i_stat.cur_zero || i_stat.nq_zero) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_BAD_SLEEP;
                        end else begin
                            o_cmd.act = ACT_SLEEP;
                            n_state   = S_NQ;
                        end
                    end
                    OP_QUERY: begin
                        if (!i_stat.tid_valid) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_INVALID;
                        end
                    end
                    default: ;
                endcase
            end
            S_SPAWN: begin
                if (i_stat.spawn_end) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_FULL;
                    n_state          = S_RES_RD;
                end else if (i_stat.spawn_free) begin
                    o_cmd.act = ACT_SPAWN_TAKE;
                    n_state   = S_RES_RD;
                end else begin
                    o_cmd.act = ACT_SPAWN_STEP;
                end
            end
            S_NQ: begin
                o_cmd.act = ACT_NQ_START;
                n_state   = S_WAKE;
            end
            S_WAKE: begin
                if (i_stat.wake_done) begin
                    o_cmd.act = ACT_REQUEUE;
                    n_state   = S_POP_RD;
                end else begin
                    o_cmd.act = ACT_WAKE_STEP;
                end
            end
            S_POP_RD: begin
                n_state = i_stat.q_empty ? S_RES_RD : S_POP;
            end
            S_POP: begin
                o_cmd.act = ACT_POP;
                n_state   = S_RUN_INC;
            end
            S_RUN_INC: begin
                o_cmd.act = ACT_RUN_WR;
                n_state   = S_RES_RD;
            end
            S_RM_INIT: begin
                o_cmd.act = ACT_RM_START;
                n_state   = S_RM;
            end
            S_RM: begin
                if (i_stat.rm_done) begin
                    o_cmd.act = ACT_RM_END;
                    n_state   = S_RES_RD;
                end else begin
                    o_cmd.act = ACT_RM_STEP;
                end
            end
            S_RES_RD: begin
                n_state = S_RES;
            end
            S_RES: begin
                if (i_stat.out_free) begin
                    o_cmd.act = ACT_RES_OUT;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[src/rrts_dp.sv]
// Datapath of the thread scheduler: thread table, ready queue, counters, result register.
module rrts_dp #(
    parameter int N = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rrts_pkg::t_dp_cmd  i_cmd,
    output rrts_pkg::t_dp_stat o_stat,
    input  logic [2:0]         i_operation,
    input  logic [5:0]         i_thread_id,
    input  logic [63:0]        i_entry_address,
    input  logic [30:0]        i_sleep_quanta,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic [2:0]         o_status,
    output logic [5:0]         o_spawn_id,
    output logic [5:0]         o_running_thread,
    output logic [30:0]        o_total_quanta,
    output logic [30:0]        o_thread_quanta,
    output logic               o_switched
);

    import rrts_pkg::*;

    localparam int IW = $clog2(N);
    localparam int CW = $clog2(N + 1);
    localparam int SW = CW + 1;

    // circular queue position: (a + b) mod N, with a < N and b <= N
    function automatic logic [IW-1:0] f_wrap(input logic [IW-1:0] a, input logic [CW-1:0] b);
        logic [SW-1:0] s;
        s = SW'(a) + SW'(b);
        if (s >= SW'(N)) begin
            s = s - SW'(N);
        end
        return s[IW-1:0];
    endfunction

    t_act act;

    // current event
    logic [2:0]  r_op;
    logic [5:0]  r_tid;
    logic        r_entry_zero;
    logic [30:0] r_nq;
    t_status     r_status;
    logic [5:0]  r_newid;
    logic        r_sw;

    // thread table and scheduler state
    logic [N-1:0]  r_live;
    logic [N-1:0]  r_pend;
    logic [N-1:0]  r_runv;
    t_mode         r_mode [N];
    logic [IW-1:0] r_head;
    logic [CW-1:0] r_cnt;
    logic [IW-1:0] r_cur;
    logic [30:0]   r_total;
    logic [CW-1:0] r_live_cnt;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_w;
    logic          r_pv;
    logic [IW-1:0] r_pix;
    logic          r_requeue;
    logic [IW-1:0] r_run_ra;

    // result register
    logic        r_ov;
    logic [2:0]  r_o_status;
    logic [5:0]  r_o_new;
    logic [5:0]  r_o_run;
    logic [30:0] r_o_total;
    logic [30:0] r_o_tq;
    logic        r_o_sw;

    logic [8:0]    tid_ext;
    logic          tid_ok;
    logic [IW-1:0] tid_ix;
    logic          tid_valid;
    logic [IW-1:0] idx_ix;
    logic          idx_lt_n;
    logic          idx_lt_cnt;
    logic          q_full;
    logic [IW-1:0] tail;

    logic [30:0]   wk_rd;
    logic [30:0]   run_rd;
    logic [IW-1:0] q_rd;
    logic [30:0]   run_val;
    logic [30:0]   run_inc;
    logic [IW-1:0] run_ra;
    logic [31:0]   wake_sum;
    logic [30:0]   wake_val;

    logic          wk_hit;
    logic          wk_ready;
    logic          rq_push;
    logic          do_push;
    logic          push_ok;
    logic [IW-1:0] push_id;
    logic          rm_keep;
    logic          q_we;
    logic [IW-1:0] q_wa;
    logic [IW-1:0] q_wd;
    logic [IW-1:0] q_ra;

    assign act = i_cmd.act;

    // target id decode
    assign tid_ext   = {3'b000, r_tid};
    assign tid_ok    = tid_ext < 9'(N);
    assign tid_ix    = tid_ext[IW-1:0];
    assign tid_valid = tid_ok && r_live[tid_ix];

    assign idx_ix     = r_idx[IW-1:0];
    assign idx_lt_n   = r_idx < CW'(N);
    assign idx_lt_cnt = r_idx < r_cnt;
    assign q_full     = (r_cnt == CW'(N));
    assign tail       = f_wrap(r_head, r_cnt);

    // run count: an entry never written since reset reads as its reset value
    assign run_val = r_runv[r_run_ra] ? run_rd : ((r_run_ra == '0) ? 31'd1 : 31'd0);
    assign run_inc = (run_val == CNT_MAX) ? run_val : run_val + 31'd1;
    assign run_ra  = (act == ACT_POP) ? q_rd : tid_ix;

    // wake time of a sleep, saturating
    assign wake_sum = {1'b0, r_total} + {1'b0, r_nq} + 32'd1;
    assign wake_val = wake_sum[31] ? CNT_MAX : wake_sum[30:0];

    // wake scan check, in the cycle after its RAM read
    assign wk_hit   = r_pv && r_pend[r_pix] && (wk_rd <= r_total);
    assign wk_ready = wk_hit && r_live[r_pix] && (r_mode[r_pix] == MODE_SLEEP);
    assign rq_push  = r_requeue && r_live[r_cur] && (r_mode[r_cur] == MODE_RUN);

    // queue push source
    always_comb begin
        do_push = 1'b0;
        push_id = r_cur;
        case (act)
            ACT_SPAWN_TAKE: begin
                do_push = 1'b1;
                push_id = idx_ix;
            end
            ACT_RESUME_PUSH: begin
                do_push = 1'b1;
                push_id = tid_ix;
            end
            ACT_WAKE_STEP: begin
                do_push = wk_ready;
                push_id = r_pix;
            end
            ACT_REQUEUE: begin
                do_push = rq_push;
                push_id = r_cur;
            end
            default: ;
        endcase
    end

    assign push_ok = do_push && !q_full;
    assign rm_keep = (act == ACT_RM_STEP) && r_pv && (q_rd != tid_ix);

    // queue RAM port selection
    assign q_we = push_ok || rm_keep;
    assign q_wa = (act == ACT_RM_STEP) ? f_wrap(r_head, r_w) : tail;
    assign q_wd = (act == ACT_RM_STEP) ? q_rd : push_id;
    assign q_ra = (act == ACT_RM_STEP) ? f_wrap(r_head, r_idx) : r_head;

    rrts_ram #(.W(31), .D(N)) u_wake_ram (
        .i_clk   (i_clk),
        .i_we    (act == ACT_SLEEP),
        .i_waddr (r_cur),
        .i_wdata (wake_val),
        .i_raddr (idx_ix),
        .o_rdata (wk_rd)
    );

    rrts_ram #(.W(31), .D(N)) u_run_ram (
        .i_clk   (i_clk),
        .i_we    (act == ACT_RUN_WR),
        .i_waddr (r_cur),
        .i_wdata (run_inc),
        .i_raddr (run_ra),
        .o_rdata (run_rd)
    );

    rrts_ram #(.W(IW), .D(N)) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_wa),
        .i_wdata (q_wd),
        .i_raddr (q_ra),
        .o_rdata (q_rd)
    );

    // thread table, queue pointers and scan counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || act == ACT_RESET_ALL) begin
            r_live <= N'(1);
            r_pend <= '0;
            r_runv <= '0;
            for (int k = 0; k < N; k++) begin
                r_mode[k] <= (k == 0) ? MODE_RUN : MODE_READY;
            end
            r_head     <= '0;
            r_cnt      <= '0;
            r_cur      <= '0;
            r_total    <= 31'd1;
            r_live_cnt <= CW'(1);
            r_idx      <= '0;
            r_w        <= '0;
            r_pv       <= 1'b0;
            r_pix      <= '0;
            r_requeue  <= 1'b0;
        end else begin
            if (push_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end
            case (act)
                ACT_SPAWN_START: begin
                    r_idx <= '0;
                end
                ACT_SPAWN_STEP: begin
                    r_idx <= r_idx + 1'b1;
                end
                ACT_SPAWN_TAKE: begin
                    r_live[idx_ix] <= 1'b1;
                    r_mode[idx_ix] <= MODE_READY;
                    r_runv[idx_ix] <= 1'b0;
                    r_pend[idx_ix] <= 1'b0;
                    r_live_cnt     <= r_live_cnt + 1'b1;
                end
                ACT_TERM: begin
                    r_live[tid_ix] <= 1'b0;
                    r_pend[tid_ix] <= 1'b0;
                    if (r_live_cnt != '0) begin
                        r_live_cnt <= r_live_cnt - 1'b1;
                    end
                end
                ACT_MODE: begin
                    r_mode[tid_ix] <= i_cmd.mode;
                end
                ACT_RESUME_PUSH: begin
                    r_mode[tid_ix] <= MODE_READY;
                end
                ACT_SLEEP: begin
                    r_pend[r_cur] <= 1'b1;
                    r_mode[r_cur] <= MODE_SLEEP;
                end
                ACT_NQ_START: begin
                    r_total   <= (r_total == CNT_MAX) ? r_total : r_total + 31'd1;
                    r_idx     <= '0;
                    r_pv      <= 1'b0;
                    r_requeue <= (r_op == OP_TICK);
                end
                ACT_WAKE_STEP: begin
                    r_pv  <= idx_lt_n;
                    r_pix <= idx_ix;
                    if (idx_lt_n) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (wk_hit) begin
                        r_pend[r_pix] <= 1'b0;
                        if (wk_ready) begin
                            r_mode[r_pix] <= MODE_READY;
                        end
                    end
                end
                ACT_REQUEUE: begin
                    if (rq_push) begin
                        r_mode[r_cur] <= MODE_READY;
                    end
                end
                ACT_POP: begin
                    r_head       <= f_wrap(r_head, CW'(1));
                    r_cnt        <= r_cnt - 1'b1;
                    r_mode[q_rd] <= MODE_RUN;
                    r_cur        <= q_rd;
                end
                ACT_RUN_WR: begin
                    r_runv[r_cur] <= 1'b1;
                end
                ACT_RM_START: begin
                    r_idx <= '0;
                    r_w   <= '0;
                    r_pv  <= 1'b0;
                end
                ACT_RM_STEP: begin
                    r_pv <= idx_lt_cnt;
                    if (idx_lt_cnt) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (rm_keep) begin
                        r_w <= r_w + 1'b1;
                    end
                end
                ACT_RM_END: begin
                    r_cnt <= r_w;
                end
                default: ;
            endcase
        end
    end

    // run count read address follows the RAM read
    always_ff @(posedge i_clk) begin
        r_run_ra <= run_ra;
    end

    // event registers
    always_ff @(posedge i_clk) begin
        if (act == ACT_LOAD) begin
            r_op         <= i_operation;
            r_tid        <= i_thread_id;
            r_entry_zero <= (i_entry_address == 64'd0);
            r_nq         <= i_sleep_quanta;
            r_status     <= ST_OK;
            r_newid      <= 6'd0;
            r_sw         <= 1'b0;
        end else begin
            if (i_cmd.set_status) begin
                r_status <= i_cmd.status;
            end
            if (act == ACT_SPAWN_TAKE) begin
                r_newid <= 6'(r_idx);
            end
            if (act == ACT_POP) begin
                r_sw <= 1'b1;
            end
        end
    end

    // result register, held while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (act == ACT_RES_OUT) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (act == ACT_RES_OUT) begin
            r_o_status <= r_status;
            r_o_new    <= r_newid;
            r_o_run    <= 6'(r_cur);
            r_o_total  <= r_total;
            r_o_tq     <= tid_valid ? run_val : 31'd0;
            r_o_sw     <= r_sw;
        end
    end

    // status toward the controller
    assign o_stat.op         = r_op;
    assign o_stat.tid_valid  = tid_valid;
    assign o_stat.tid_zero   = (r_tid == 6'd0);
    assign o_stat.tid_mode   = r_mode[tid_ix];
    assign o_stat.tid_pend   = r_pend[tid_ix];
    assign o_stat.entry_zero = r_entry_zero;
    assign o_stat.full       = (r_live_cnt >= CW'(N));
    assign o_stat.cur_zero   = (r_cur == '0);
    assign o_stat.nq_zero    = (r_nq == 31'd0);
    assign o_stat.spawn_end  = !idx_lt_n;
    assign o_stat.spawn_free = !r_live[idx_ix];
    assign o_stat.wake_done  = !idx_lt_n && !r_pv;
    assign o_stat.q_empty    = (r_cnt == '0);
    assign o_stat.rm_done    = !idx_lt_cnt && !r_pv;
    assign o_stat.out_free   = !r_ov || !i_out_stall;

    assign o_out_valid      = r_ov;
    assign o_status         = r_o_status;
    assign o_spawn_id       = r_o_new;
    assign o_running_thread = r_o_run;
    assign o_total_quanta   = r_o_total;
    assign o_thread_quanta  = r_o_tq;
    assign o_switched       = r_o_sw;

endmodule

[src/round_robin_thread_scheduler_top.sv]
// Top level of the round-robin thread scheduler.
//
// Input channel (i_in_valid / o_in_stall) carries one scheduling event: operation,
// thread_id, entry_address and sleep_quanta. Output channel (o_out_valid /
// i_out_stall) returns exactly one result per event.
// One event is handled at a time; o_in_stall is high from the cycle after a transfer
// until the result has been loaded into the output register.
// Rejected events, query, resume, block/terminate of a blocked or sleeping thread
// go straight to the result; spawn searches the ids upward for the lowest free one;
// removing a ready thread walks the ready queue; tick, sleep, or block/terminate of
// the running thread run the wake scan over all MAX_THREADS entries, one entry per
// cycle; a tick then requeues the running thread, and a nonempty queue is popped.
// A finished result sits in the output register while the next event is taken in.
// Reset (synchronous, active low) leaves thread 0 running, total quanta at one and
// the ready queue empty; terminating thread 0 restores the same state.
// While the receiver stalls, the result is held and the block stops only once a
// second result is ready to be loaded.
module round_robin_thread_scheduler_top #(
    parameter int MAX_THREADS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_operation,
    input  logic [5:0]  i_thread_id,
    input  logic [63:0] i_entry_address,
    input  logic [30:0] i_sleep_quanta,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [5:0]  o_spawn_id,
    output logic [5:0]  o_running_thread,
    output logic [30:0] o_total_quanta,
    output logic [30:0] o_thread_quanta,
    output logic        o_switched
);

    import rrts_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencing
    rrts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // tables, queue and result register
    rrts_dp #(.N(MAX_THREADS)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_operation      (i_operation),
        .i_thread_id      (i_thread_id),
        .i_entry_address  (i_entry_address),
        .i_sleep_quanta   (i_sleep_quanta),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_status         (o_status),
        .o_spawn_id       (o_spawn_id),
        .o_running_thread (o_running_thread),
        .o_total_quanta   (o_total_quanta),
        .o_thread_quanta  (o_thread_quanta),
        .o_switched       (o_switched)
    );

endmodule

[src/rrts_checker.sv]
// Port-level assertions for the thread scheduler and their bind.
module rrts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_status,
    input logic [5:0]  o_spawn_id,
    input logic [5:0]  o_running_thread,
    input logic [30:0] o_total_quanta,
    input logic [30:0] o_thread_quanta,
    input logic        o_switched
);

    import rrts_pkg::*;

    // a stalled result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_thread_quanta) && $stable(o_running_thread)
            && $stable(o_spawn_id) && $stable(o_total_quanta) && $stable(o_switched))
        else $error("result changed under stall");

    // one event at a time: busy right after an input transfer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while an event is in progress");

    // a dispatch only happens on a successful event
    a_switch_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_switched |-> o_status == ST_OK)
        else $error("switch reported with error status");

    // process exit returns to the reset state
    a_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_EXIT |->
            o_running_thread == 6'd0 && o_total_quanta == 31'd1 && !o_switched)
        else $error("exit did not restore reset state");

endmodule

bind round_robin_thread_scheduler_top rrts_checker u_rrts_checker (.*);
